// ===== src/packet_buffer_pool_writer_top_assert.svh =====
// assertion macros for the packet buffer pool writer
`ifndef PACKET_BUFFER_POOL_WRITER_TOP_ASSERT_SVH
`define PACKET_BUFFER_POOL_WRITER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PBPW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pbpw assertion failed");
`define PBPW_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("pbpw forbidden condition seen");
`else
`define PBPW_ASSERT(lbl, prop)
`define PBPW_NEVER(lbl, expr)
`endif

`endif

// ===== src/pbpw_pkg.sv =====
`timescale 1ns / 1ps
package pbpw_pkg;

  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned FILL_W       = 13;
  localparam int unsigned HL_W         = 14;
  localparam int unsigned SUM_W        = 15;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned CNT_CFG_W    = 3;

  typedef enum logic [1:0] {
    CMD_BEGIN   = 2'd0,
    CMD_BYTE    = 2'd1,
    CMD_COMMIT  = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFERS_IN_USE = 2'd1;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic              kind;
    logic [1:0]        wr_buffer;
    logic [11:0]       wr_offset;
    logic [7:0]        wr_byte;
    logic              accepted;
    logic              overflow;
    logic              too_long;
    logic              committed;
    logic [1:0]        active_buf;
    logic [3:0]        ready_mask;
    logic [FILL_W-1:0] fill;
    logic              last;
  } res_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic found;
  } scan_res_t;

endpackage

// ===== src/packet_buffer_pool_writer_top.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    in_cmd in_pkt_type in_pkt_length in_data_byte
//                                           in_buffer_index
// out       output     out_valid/out_ready  out_kind out_wr_* out_accepted ... out_last
// cfg       input      cfg_valid/cfg_ready  cfg_index cfg_data
//
// one word at a time; a switch scan and a commit scan at packet end each step one buffer
// per cycle, and the shared adder and the single fill memory read port serialize the work
// synchronous rst_n clears control state and fill valid bits, no clearing pass
// out_ready low holds the sequencer in its emit state, cfg_ready is always high
`include "packet_buffer_pool_writer_top_assert.svh"
module packet_buffer_pool_writer_top
  import pbpw_pkg::*;
#(
  parameter int unsigned NUM_BUFFERS     = 4,
  parameter int unsigned BUFFER_CAPACITY = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_cmd,
  input  logic [31:0]           in_pkt_type,
  input  logic [FILL_W-1:0]     in_pkt_length,
  input  logic [7:0]            in_data_byte,
  input  logic [1:0]            in_buffer_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_kind,
  output logic [1:0]            out_wr_buffer,
  output logic [11:0]           out_wr_offset,
  output logic [7:0]            out_wr_byte,
  output logic                  out_accepted,
  output logic                  out_overflow,
  output logic                  out_too_long,
  output logic                  out_committed,
  output logic [1:0]            out_active_buf,
  output logic [3:0]            out_ready_mask,
  output logic [FILL_W-1:0]     out_fill,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned IW = $clog2(NUM_BUFFERS);
  localparam int unsigned CW = $clog2(NUM_BUFFERS + 1);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_CHK   = 11'b000_0000_0010,
    ST_FIT   = 11'b000_0000_0100,
    ST_SCAN  = 11'b000_0000_1000,
    ST_HDR   = 11'b000_0001_0000,
    ST_HEND  = 11'b000_0010_0000,
    ST_OFF   = 11'b000_0100_0000,
    ST_END   = 11'b000_1000_0000,
    ST_CSCAN = 11'b001_0000_0000,
    ST_STAT  = 11'b010_0000_0000,
    ST_SOUT  = 11'b100_0000_0000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [IW-1:0]          cur_r, cur_nxt;
  logic [NUM_BUFFERS-1:0] ready_r, ready_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   pend_r, pend_nxt;
  logic [FILL_W-1:0]      rem_r, rem_nxt;
  logic                   open_r, open_nxt;
  logic                   acc_r, acc_nxt;
  logic                   tl_r, tl_nxt;
  logic                   com_r, com_nxt;
  logic [FILL_W-1:0]      bb_r, bb_nxt;
  logic [CNT_CFG_W-1:0]   biu_r, biu_nxt;
  logic [2:0]             hidx_r, hidx_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic [HL_W-1:0]        hl_r, hl_nxt;
  logic [FILL_W-1:0]      base_r, base_nxt;

  cmd_t                   cmd_r;
  logic [31:0]            type_r;
  logic [FILL_W-1:0]      len_r;
  logic [7:0]             byte_r;
  logic [1:0]             qidx_r;

  logic                   in_accept;
  logic [16:0]            bb_ext;
  logic [FILL_W-1:0]      size_w;
  logic [4:0]             biu_ext;
  logic [4:0]             cnt_ext;
  logic [CW-1:0]          cnt_w;
  logic [4:0]             q_ext;
  logic [IW-1:0]          q_addr;
  logic                   q_ok;
  logic [4:0]             cur_ext;
  logic [15:0]            ready_ext;
  logic [63:0]            hdr_word;
  logic [7:0]             hdr_byte;

  alu_op_t                alu_op;
  logic [SUM_W-1:0]       alu_a;
  logic [SUM_W-1:0]       alu_b;
  logic [SUM_W-1:0]       alu_sum;
  logic                   alu_ge;

  logic                   scan_start;
  logic                   scan_skip_en;
  scan_res_t              scan_res;
  logic [IW-1:0]          scan_idx;

  logic                   mem_we;
  logic                   mem_clr;
  logic [IW-1:0]          mem_raddr;
  logic [FILL_W-1:0]      mem_rdata;

  logic                   emit;
  res_t                   emit_res;
  logic                   out_load_ok;
  res_t                   out_res;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign bb_ext  = 17'(bb_r);
  assign size_w  = (bb_ext > 17'(BUFFER_CAPACITY)) ? FILL_W'(BUFFER_CAPACITY) : bb_r;
  assign biu_ext = 5'(biu_r);
  assign cnt_ext = (biu_ext == 5'd0) ? 5'd1 :
                   (biu_ext > 5'(NUM_BUFFERS)) ? 5'(NUM_BUFFERS) : biu_ext;
  assign cnt_w   = cnt_ext[CW-1:0];

  assign q_ext     = 5'(qidx_r);
  assign q_addr    = q_ext[IW-1:0];
  assign q_ok      = (q_ext < 5'(NUM_BUFFERS));
  assign cur_ext   = 5'(cur_r);
  assign ready_ext = 16'(ready_r);
  assign hdr_word  = {32'(len_r), type_r};
  assign hdr_byte  = hdr_word[8*hidx_r +: 8];
  assign mem_raddr = (state_r == ST_IDLE) ? cur_r : q_addr;

  pbpw_alu u_alu (
    .op   (alu_op),
    .op_a (alu_a),
    .op_b (alu_b),
    .cmp  (size_w),
    .sum  (alu_sum),
    .ge   (alu_ge)
  );

  pbpw_scan #(
    .NUM_BUFFERS (NUM_BUFFERS),
    .IW          (IW),
    .CW          (CW)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .skip_en (scan_skip_en),
    .skip    (cur_r),
    .count   (cnt_w),
    .ready_i (ready_r),
    .res     (scan_res),
    .idx     (scan_idx)
  );

  pbpw_fill_mem #(
    .DEPTH (NUM_BUFFERS),
    .AW    (IW)
  ) u_fill_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (cur_r),
    .wdata (alu_sum[FILL_W-1:0]),
    .clr   (mem_clr),
    .caddr (scan_idx),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pbpw_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (emit),
    .din       (emit_res),
    .load_ok   (out_load_ok),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .dout      (out_res)
  );

  assign out_kind       = out_res.kind;
  assign out_wr_buffer  = out_res.wr_buffer;
  assign out_wr_offset  = out_res.wr_offset;
  assign out_wr_byte    = out_res.wr_byte;
  assign out_accepted   = out_res.accepted;
  assign out_overflow   = out_res.overflow;
  assign out_too_long   = out_res.too_long;
  assign out_committed  = out_res.committed;
  assign out_active_buf = out_res.active_buf;
  assign out_ready_mask = out_res.ready_mask;
  assign out_fill       = out_res.fill;
  assign out_last       = out_res.last;

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    ready_nxt    = ready_r;
    ovf_nxt      = ovf_r;
    pend_nxt     = pend_r;
    rem_nxt      = rem_r;
    open_nxt     = open_r;
    acc_nxt      = acc_r;
    tl_nxt       = tl_r;
    com_nxt      = com_r;
    bb_nxt       = bb_r;
    biu_nxt      = biu_r;
    hidx_nxt     = hidx_r;
    fill_nxt     = fill_r;
    hl_nxt       = hl_r;
    base_nxt     = base_r;
    alu_op       = ALU_ADD;
    alu_a        = '0;
    alu_b        = '0;
    scan_start   = 1'b0;
    scan_skip_en = 1'b0;
    mem_we       = 1'b0;
    mem_clr      = 1'b0;
    emit         = 1'b0;
    emit_res     = '0;

    if (cfg_valid) begin
      case (cfg_index)
        REG_BUFFER_BYTES:   bb_nxt  = cfg_data;
        REG_BUFFERS_IN_USE: biu_nxt = cfg_data[CNT_CFG_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          acc_nxt   = 1'b0;
          tl_nxt    = 1'b0;
          com_nxt   = 1'b0;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        alu_a    = SUM_W'(HEADER_BYTES);
        alu_b    = SUM_W'(len_r);
        fill_nxt = mem_rdata;
        case (cmd_r)
          CMD_BEGIN: begin
            open_nxt = 1'b0;
            rem_nxt  = '0;
            hl_nxt   = alu_sum[HL_W-1:0];
            if (alu_ge) begin
              tl_nxt    = 1'b1;
              state_nxt = ST_STAT;
            end else begin
              state_nxt = ST_FIT;
            end
          end
          CMD_BYTE: begin
            state_nxt = (open_r && (rem_r != '0)) ? ST_OFF : ST_STAT;
          end
          CMD_COMMIT: begin
            pend_nxt  = 1'b1;
            state_nxt = ST_STAT;
          end
          CMD_RELEASE: begin
            if (q_ok) begin
              ready_nxt[q_addr] = 1'b0;
            end
            state_nxt = ST_STAT;
          end
          default: state_nxt = ST_STAT;
        endcase
      end
      ST_FIT: begin
        alu_a = SUM_W'(fill_r);
        alu_b = SUM_W'(hl_r);
        if (alu_ge) begin
          ready_nxt[cur_r] = 1'b1;
          scan_start       = 1'b1;
          state_nxt        = ST_SCAN;
        end else begin
          base_nxt  = fill_r;
          hidx_nxt  = '0;
          state_nxt = ST_HDR;
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          if (scan_res.found) begin
            ovf_nxt   = 1'b0;
            cur_nxt   = scan_idx;
            mem_clr   = 1'b1;
            base_nxt  = '0;
            hidx_nxt  = '0;
            state_nxt = ST_HDR;
          end else begin
            ovf_nxt   = 1'b1;
            state_nxt = ST_STAT;
          end
        end
      end
      ST_HDR: begin
        alu_a = SUM_W'(base_r);
        alu_b = SUM_W'(hidx_r);
        if (out_load_ok) begin
          emit               = 1'b1;
          emit_res.kind      = KIND_WRITE;
          emit_res.wr_buffer = cur_ext[1:0];
          emit_res.wr_offset = alu_sum[11:0];
          emit_res.wr_byte   = hdr_byte;
          emit_res.accepted  = 1'b1;
          hidx_nxt           = hidx_r + 3'd1;
          if (hidx_r == 3'(HEADER_BYTES - 1)) begin
            state_nxt = ST_HEND;
          end
        end
      end
      ST_HEND: begin
        alu_a   = SUM_W'(base_r);
        alu_b   = SUM_W'(hl_r);
        mem_we  = 1'b1;
        acc_nxt = 1'b1;
        if (len_r == '0) begin
          state_nxt = ST_END;
        end else begin
          open_nxt  = 1'b1;
          rem_nxt   = len_r;
          state_nxt = ST_STAT;
        end
      end
      ST_OFF: begin
        alu_op = ALU_SUB;
        alu_a  = SUM_W'(fill_r);
        alu_b  = SUM_W'(rem_r);
        if (out_load_ok) begin
          emit               = 1'b1;
          emit_res.kind      = KIND_WRITE;
          emit_res.wr_buffer = cur_ext[1:0];
          emit_res.wr_offset = alu_sum[11:0];
          emit_res.wr_byte   = byte_r;
          emit_res.accepted  = 1'b1;
          acc_nxt            = 1'b1;
          rem_nxt            = rem_r - FILL_W'(1);
          if (rem_r == FILL_W'(1)) begin
            open_nxt  = 1'b0;
            state_nxt = ST_END;
          end else begin
            state_nxt = ST_STAT;
          end
        end
      end
      ST_END: begin
        if (pend_r) begin
          pend_nxt     = 1'b0;
          scan_start   = 1'b1;
          scan_skip_en = 1'b1;
          state_nxt    = ST_CSCAN;
        end else begin
          state_nxt = ST_STAT;
        end
      end
      ST_CSCAN: begin
        if (scan_res.done) begin
          if (scan_res.found) begin
            ready_nxt[cur_r] = 1'b1;
            ovf_nxt          = 1'b0;
            cur_nxt          = scan_idx;
            mem_clr          = 1'b1;
            com_nxt          = 1'b1;
          end
          state_nxt = ST_STAT;
        end
      end
      ST_STAT: begin
        state_nxt = ST_SOUT;
      end
      ST_SOUT: begin
        if (out_load_ok) begin
          emit                = 1'b1;
          emit_res.kind       = KIND_STATUS;
          emit_res.accepted   = acc_r;
          emit_res.overflow   = ovf_r;
          emit_res.too_long   = tl_r;
          emit_res.committed  = com_r;
          emit_res.active_buf = cur_ext[1:0];
          emit_res.ready_mask = ready_ext[3:0];
          emit_res.fill       = q_ok ? mem_rdata : '0;
          emit_res.last       = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cur_r   <= '0;
      ready_r <= '0;
      ovf_r   <= 1'b0;
      pend_r  <= 1'b0;
      rem_r   <= '0;
      open_r  <= 1'b0;
      acc_r   <= 1'b0;
      tl_r    <= 1'b0;
      com_r   <= 1'b0;
      bb_r    <= 13'd4096;
      biu_r   <= 3'd4;
      hidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      ready_r <= ready_nxt;
      ovf_r   <= ovf_nxt;
      pend_r  <= pend_nxt;
      rem_r   <= rem_nxt;
      open_r  <= open_nxt;
      acc_r   <= acc_nxt;
      tl_r    <= tl_nxt;
      com_r   <= com_nxt;
      bb_r    <= bb_nxt;
      biu_r   <= biu_nxt;
      hidx_r  <= hidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_r <= fill_nxt;
    hl_r   <= hl_nxt;
    base_r <= base_nxt;
    if (in_accept) begin
      cmd_r  <= cmd_t'(in_cmd);
      type_r <= in_pkt_type;
      len_r  <= in_pkt_length;
      byte_r <= in_data_byte;
      qidx_r <= in_buffer_index;
    end
  end

  `PBPW_ASSERT(a_open_has_bytes, open_r |-> (rem_r != '0))
  `PBPW_NEVER(a_mem_wr_and_clr, mem_we && mem_clr)
  `PBPW_ASSERT(a_scan_start_idle, scan_start |-> !scan_res.busy)
  `PBPW_ASSERT(a_status_ends_item, (emit && emit_res.last) |=> in_ready)

endmodule

// ===== src/pbpw_alu.sv =====
`timescale 1ns / 1ps
module pbpw_alu
  import pbpw_pkg::*;
(
  input  alu_op_t           op,
  input  logic [SUM_W-1:0]  op_a,
  input  logic [SUM_W-1:0]  op_b,
  input  logic [FILL_W-1:0] cmp,
  output logic [SUM_W-1:0]  sum,
  output logic              ge
);

  always_comb begin
    case (op)
      ALU_ADD: sum = op_a + op_b;
      ALU_SUB: sum = op_a - op_b;
      default: sum = op_a + op_b;
    endcase
  end

  assign ge = (sum >= SUM_W'(cmp));

endmodule

// ===== src/pbpw_scan.sv =====
`timescale 1ns / 1ps
module pbpw_scan
  import pbpw_pkg::*;
#(
  parameter int unsigned NUM_BUFFERS = 4,
  parameter int unsigned IW          = 2,
  parameter int unsigned CW          = 3
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   skip_en,
  input  logic [IW-1:0]          skip,
  input  logic [CW-1:0]          count,
  input  logic [NUM_BUFFERS-1:0] ready_i,
  output scan_res_t              res,
  output logic [IW-1:0]          idx
);

  logic [CW-1:0] pos_r, pos_nxt;
  logic          busy_r, busy_nxt;
  logic          skip_en_r, skip_en_nxt;
  logic [IW-1:0] skip_r, skip_nxt;
  logic          at_end;
  logic          hit;

  assign at_end = (pos_r >= count);
  assign idx    = pos_r[IW-1:0];
  assign hit    = !at_end && !ready_i[idx] && !(skip_en_r && (idx == skip_r));

  assign res.busy  = busy_r;
  assign res.done  = busy_r && (at_end || hit);
  assign res.found = busy_r && hit;

  always_comb begin
    pos_nxt     = pos_r;
    busy_nxt    = busy_r;
    skip_en_nxt = skip_en_r;
    skip_nxt    = skip_r;
    if (start) begin
      pos_nxt     = '0;
      busy_nxt    = 1'b1;
      skip_en_nxt = skip_en;
      skip_nxt    = skip;
    end else if (res.done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      pos_nxt = pos_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      busy_r    <= 1'b0;
      skip_en_r <= 1'b0;
      skip_r    <= '0;
    end else begin
      pos_r     <= pos_nxt;
      busy_r    <= busy_nxt;
      skip_en_r <= skip_en_nxt;
      skip_r    <= skip_nxt;
    end
  end

endmodule

// ===== src/pbpw_fill_mem.sv =====
`timescale 1ns / 1ps
module pbpw_fill_mem
  import pbpw_pkg::*;
#(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned AW    = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [FILL_W-1:0] wdata,
  input  logic              clr,
  input  logic [AW-1:0]     caddr,
  input  logic [AW-1:0]     raddr,
  output logic [FILL_W-1:0] rdata
);

  logic [FILL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_r, valid_nxt;
  logic [FILL_W-1:0] rdata_r;

  assign rdata = rdata_r;

  always_comb begin
    valid_nxt = valid_r;
    if (clr) begin
      valid_nxt[caddr] = 1'b0;
    end
    if (we) begin
      valid_nxt[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= valid_r[raddr] ? mem[raddr] : '0;
  end

endmodule

// ===== src/pbpw_out_reg.sv =====
`timescale 1ns / 1ps
module pbpw_out_reg
  import pbpw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t din,
  output logic load_ok,
  input  logic out_ready,
  output logic out_valid,
  output res_t dout
);

  logic valid_r, valid_nxt;
  res_t data_r;

  assign load_ok   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign dout      = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= din;
    end
  end

endmodule
